/* src/vec2d_pkg.sv */
// ----------------------------------------------------------------------------
// vec2d_pkg: shared types and helpers for the 2-D vector ALU
// Q-format constants, opcodes, pipeline stage record, saturation and divider-step helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vec2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = DATA_W + FRAC_BITS;  // dividend / quotient width
  localparam int RAD_W     = 2 * DIV_W;           // radicand, two bits per stage
  localparam int SQ_REM_W  = DATA_W + 2;
  localparam int SQ_ROOT_W = DATA_W;

  localparam logic [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5,
    OP_LEN = 3'd6
  } op_e;

  // one restoring-division lane: dividend shifts out the top, quotient in the bottom
  typedef struct packed {
    logic [DIV_W-1:0]  rq;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dsr;
    logic              neg;
    logic              zero;
  } div_lane_t;

  typedef struct packed {
    op_e                  op;
    logic [DATA_W-1:0]    rx;
    logic [DATA_W-1:0]    ry;
    logic                 cmp;
    div_lane_t            dx;
    div_lane_t            dy;
    logic [RAD_W-1:0]     rad;
    logic [SQ_REM_W-1:0]  srem;
    logic [SQ_ROOT_W-1:0] root;
  } stage_t;

  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? RAW_MIN : RAW_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat_wide(input logic [2*DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    if ((&v[2*DATA_W-1:DATA_W-1]) || !(|v[2*DATA_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[2*DATA_W-1] ? RAW_MIN : RAW_MAX;
    end
    return r;
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t       r;
    logic [DATA_W:0] t;
    logic [DATA_W:0] d;
    t = {l.rem, l.rq[DIV_W-1]};
    d = {1'b0, l.dsr};
    r = l;
    if (t >= d) begin
      r.rem = DATA_W'(t - d);
      r.rq  = {l.rq[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = t[DATA_W-1:0];
      r.rq  = {l.rq[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] div_final(input div_lane_t l);
    logic [DATA_W-1:0] r;
    if (l.zero) begin
      r = '0;
    end else if (l.neg) begin
      r = (l.rq > {{FRAC_BITS{1'b0}}, RAW_MIN}) ? RAW_MIN : DATA_W'(-l.rq);
    end else begin
      r = (l.rq > {{FRAC_BITS{1'b0}}, RAW_MAX}) ? RAW_MAX : l.rq[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/vector2d_alu_core.sv */
// Depth is set by the restoring divider at Q16.16, one quotient bit a stage.
// Throughput: one request per cycle unless stalled; sqrt shares the stages, two bits each.
// Stall: all stages hold together while the output register is full and not taken.
// Reset: only the valid bits clear (asynchronous, active low); data registers are not reset.
// ----------------------------------------------------------------------------
// vector2d_alu_core: pipelined 2-D vector ALU in signed Q16.16
// Add, subtract, multiply, divide, compare and length of A, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module vector2d_alu_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [127:0]  s_axis_tdata,   // a_x, a_y, b_x, b_y (from bit 0)
  input  wire logic [2:0]    s_axis_tuser,   // opcode
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // result_x, result_y (from bit 0)
  output logic [0:0]         m_axis_tuser    // compare_true
);
  import vec2d_pkg::*;

  logic   en;
  logic   valid_pipe [DIV_W+1];
  stage_t pipe       [DIV_W+1];
  logic   out_valid;
  logic   out_cmp;
  logic [DATA_W-1:0] out_rx, out_ry;

  // whole pipe advances unless the output request is waiting
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  vec2d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (op_e'(s_axis_tuser)),
    .a_x_i   (s_axis_tdata[31:0]),
    .a_y_i   (s_axis_tdata[63:32]),
    .b_x_i   (s_axis_tdata[95:64]),
    .b_y_i   (s_axis_tdata[127:96]),
    .valid_o (valid_pipe[0]),
    .pipe_o  (pipe[0])
  );

  // divide and square-root iteration chain
  for (genvar g = 0; g < DIV_W; g++) begin : g_iter
    vec2d_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_pipe[g]),
      .pipe_i  (pipe[g]),
      .valid_o (valid_pipe[g+1]),
      .pipe_o  (pipe[g+1])
    );
  end

  vec2d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_pipe[DIV_W]),
    .pipe_i  (pipe[DIV_W]),
    .valid_o (out_valid),
    .rx_o    (out_rx),
    .ry_o    (out_ry),
    .cmp_o   (out_cmp)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_ry, out_rx};
  assign m_axis_tuser  = out_cmp;

endmodule

`default_nettype wire

/* src/vec2d_front.sv */
// ----------------------------------------------------------------------------
// vec2d_front: two-stage operand preparation
// Sum/difference/compare, products and squares, then product scaling and
// radicand build; seeds the divider and square-root lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module vec2d_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire vec2d_pkg::op_e                op_i,
  input  wire logic [vec2d_pkg::DATA_W-1:0]  a_x_i,
  input  wire logic [vec2d_pkg::DATA_W-1:0]  a_y_i,
  input  wire logic [vec2d_pkg::DATA_W-1:0]  b_x_i,
  input  wire logic [vec2d_pkg::DATA_W-1:0]  b_y_i,
  output logic                               valid_o,
  output vec2d_pkg::stage_t                  pipe_o
);
  import vec2d_pkg::*;

  logic signed [DATA_W-1:0]   ax, ay, bx, by;
  logic [DATA_W-1:0]          mag_ax, mag_ay, mag_bx, mag_by;
  logic [DATA_W-1:0]          sum_x, sum_y, dif_x, dif_y;
  logic                       eq;

  // stage 1
  logic                       v1_q;
  op_e                        op1_q, op1_d;
  logic [DATA_W-1:0]          rx1_q, rx1_d, ry1_q, ry1_d;
  logic                       cmp1_q, cmp1_d;
  logic signed [2*DATA_W-1:0] px_q, px_d, py_q, py_d;
  logic [2*DATA_W-1:0]        sx_q, sx_d, sy_q, sy_d;
  div_lane_t                  dx1_q, dx1_d, dy1_q, dy1_d;

  // stage 2
  logic                       v2_q;
  stage_t                     s2_q, s2_d;
  logic signed [2*DATA_W-1:0] fx, fy;

  assign ax = a_x_i;
  assign ay = a_y_i;
  assign bx = b_x_i;
  assign by = b_y_i;

  assign mag_ax = ax[DATA_W-1] ? DATA_W'(-ax) : a_x_i;
  assign mag_ay = ay[DATA_W-1] ? DATA_W'(-ay) : a_y_i;
  assign mag_bx = bx[DATA_W-1] ? DATA_W'(-bx) : b_x_i;
  assign mag_by = by[DATA_W-1] ? DATA_W'(-by) : b_y_i;

  assign sum_x = sat_sum({a_x_i[DATA_W-1], a_x_i} + {b_x_i[DATA_W-1], b_x_i});
  assign sum_y = sat_sum({a_y_i[DATA_W-1], a_y_i} + {b_y_i[DATA_W-1], b_y_i});
  assign dif_x = sat_sum({a_x_i[DATA_W-1], a_x_i} - {b_x_i[DATA_W-1], b_x_i});
  assign dif_y = sat_sum({a_y_i[DATA_W-1], a_y_i} - {b_y_i[DATA_W-1], b_y_i});
  assign eq    = (a_x_i == b_x_i) && (a_y_i == b_y_i);

  always_comb begin
    op1_d  = op_i;
    rx1_d  = '0;
    ry1_d  = '0;
    cmp1_d = 1'b0;
    unique case (op_i)
      OP_ADD: begin
        rx1_d = sum_x;
        ry1_d = sum_y;
      end
      OP_SUB: begin
        rx1_d = dif_x;
        ry1_d = dif_y;
      end
      OP_EQ:   cmp1_d = eq;
      OP_NE:   cmp1_d = !eq;
      default: ;
    endcase
    px_d = ax * bx;
    py_d = ay * by;
    sx_d = mag_ax * mag_ax;
    sy_d = mag_ay * mag_ay;
    dx1_d.rq   = {mag_ax, {FRAC_BITS{1'b0}}};
    dx1_d.rem  = '0;
    dx1_d.dsr  = mag_bx;
    dx1_d.neg  = a_x_i[DATA_W-1] ^ b_x_i[DATA_W-1];
    dx1_d.zero = (b_x_i == '0);
    dy1_d.rq   = {mag_ay, {FRAC_BITS{1'b0}}};
    dy1_d.rem  = '0;
    dy1_d.dsr  = mag_by;
    dy1_d.neg  = a_y_i[DATA_W-1] ^ b_y_i[DATA_W-1];
    dy1_d.zero = (b_y_i == '0);
  end

  // floor of the product scaled back to Q format
  assign fx = px_q >>> FRAC_BITS;
  assign fy = py_q >>> FRAC_BITS;

  always_comb begin
    s2_d.op   = op1_q;
    s2_d.cmp  = cmp1_q;
    s2_d.rx   = (op1_q == OP_MUL) ? sat_wide(fx) : rx1_q;
    s2_d.ry   = (op1_q == OP_MUL) ? sat_wide(fy) : ry1_q;
    s2_d.dx   = dx1_q;
    s2_d.dy   = dy1_q;
    s2_d.rad  = RAD_W'(sx_q + sy_q);
    s2_d.srem = '0;
    s2_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= op1_d;
      rx1_q  <= rx1_d;
      ry1_q  <= ry1_d;
      cmp1_q <= cmp1_d;
      px_q   <= px_d;
      py_q   <= py_d;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      s2_q   <= s2_d;
    end
  end

  assign valid_o = v2_q;
  assign pipe_o  = s2_q;

endmodule

`default_nettype wire

/* src/vec2d_iter.sv */
// ----------------------------------------------------------------------------
// vec2d_iter: one iteration stage
// One quotient bit for each divide lane and one root bit for the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module vec2d_iter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire vec2d_pkg::stage_t pipe_i,
  output logic                   valid_o,
  output vec2d_pkg::stage_t      pipe_o
);
  import vec2d_pkg::*;

  logic                  valid_q;
  stage_t                pipe_q, pipe_d;
  logic [SQ_REM_W+1:0]   t;
  logic [SQ_REM_W+1:0]   trial;

  assign t     = {pipe_i.srem, pipe_i.rad[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, pipe_i.root, 2'b01};

  always_comb begin
    pipe_d     = pipe_i;
    pipe_d.dx  = div_step(pipe_i.dx);
    pipe_d.dy  = div_step(pipe_i.dy);
    pipe_d.rad = {pipe_i.rad[RAD_W-3:0], 2'b00};
    if (t >= trial) begin
      pipe_d.srem = SQ_REM_W'(t - trial);
      pipe_d.root = {pipe_i.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      pipe_d.srem = t[SQ_REM_W-1:0];
      pipe_d.root = {pipe_i.root[SQ_ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

`default_nettype wire

/* src/vec2d_back.sv */
// ----------------------------------------------------------------------------
// vec2d_back: result selection and output register
// Signs and saturates the quotients, clamps the root, picks by opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module vec2d_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire vec2d_pkg::stage_t            pipe_i,
  output logic                              valid_o,
  output logic [vec2d_pkg::DATA_W-1:0]      rx_o,
  output logic [vec2d_pkg::DATA_W-1:0]      ry_o,
  output logic                              cmp_o
);
  import vec2d_pkg::*;

  logic              valid_q;
  logic [DATA_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic              cmp_q;

  always_comb begin
    rx_d = pipe_i.rx;
    ry_d = pipe_i.ry;
    unique case (pipe_i.op)
      OP_DIV: begin
        rx_d = div_final(pipe_i.dx);
        ry_d = div_final(pipe_i.dy);
      end
      OP_LEN: begin
        rx_d = (pipe_i.root > RAW_MAX) ? RAW_MAX : pipe_i.root;
        ry_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      cmp_q <= pipe_i.cmp;
    end
  end

  assign valid_o = valid_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign cmp_o   = cmp_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector2d_alu_core
// Drives add/sub/mul/div/compare/length requests with random idling on both
// stream sides, predicts each result in Q16.16 and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import vec2d_pkg::*;

  localparam int  LATENCY    = 2 + DIV_W + 1;
  localparam int  STALL_LIMIT = 20000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] ry;
    logic [31:0] rx;
    logic        cmp;
  } vec_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  vec_result_t  expected_q[$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           recv_hold = 1'b0;
  int           idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vector2d_alu_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] fixed_mul(input longint a, input longint b);
    return clamp32((a * b) >>> FRAC_BITS);  // arithmetic shift floors
  endfunction

  function automatic logic [31:0] fixed_div(input longint a, input longint b);
    if (b == 0) return '0;
    return clamp32((a <<< FRAC_BITS) / b);  // SV division truncates to zero
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic vec_result_t vector_alu_result(input logic [2:0] op,
      input logic signed [31:0] ax, ay, bx, by);
    vec_result_t     r;
    longint unsigned mx, my, len;
    r = '0;
    case (op)
      OP_ADD: begin
        r.rx = clamp32(longint'(ax) + bx); r.ry = clamp32(longint'(ay) + by);
      end
      OP_SUB: begin
        r.rx = clamp32(longint'(ax) - bx); r.ry = clamp32(longint'(ay) - by);
      end
      OP_MUL: begin r.rx = fixed_mul(ax, bx); r.ry = fixed_mul(ay, by); end
      OP_DIV: begin r.rx = fixed_div(ax, bx); r.ry = fixed_div(ay, by); end
      OP_EQ:  r.cmp = (ax == bx) && (ay == by);
      OP_NE:  r.cmp = (ax != bx) || (ay != by);
      OP_LEN: begin
        mx  = (ax < 0) ? longint'(-longint'(ax)) : longint'(ax);
        my  = (ay < 0) ? longint'(-longint'(ay)) : longint'(ay);
        len = int_sqrt(mx * mx + my * my);
        r.rx = (len > 64'd2147483647) ? 32'h7fffffff : len[31:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one request, predicted on acceptance; valid stays up across back-to-back items
  task automatic send_request(input logic [2:0] op, input logic [31:0] ax, ay, bx, by);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {by, bx, ay, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(vector_alu_result(op, ax, ay, bx, by));
  endtask

  task automatic release_bus();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_component(input int sel);
    case (sel)
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return '0;
      3: return $urandom_range(2) ? 32'h00010000 : 32'hffff0000;
      4: return $signed($urandom_range(2000)) - 1000;   // small raw values
      5: return ($signed($urandom_range(200)) - 100) <<< FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random idle, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.rx)
          report_mismatch("result_x", m_axis_tdata[31:0], want.rx);
        if (m_axis_tdata[63:32] !== want.ry)
          report_mismatch("result_y", m_axis_tdata[63:32], want.ry);
        if (m_axis_tuser[0] !== want.cmp)
          report_mismatch("compare_true", {31'b0, m_axis_tuser[0]}, {31'b0, want.cmp});
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** vector2d_alu_core: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] ext[6];
    ext = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffffffff, 32'h00000001};
    send_request(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
    send_request(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
    send_request(OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_request(OP_MUL, 32'hffffffff, 32'h00018000, 32'h00000001, 32'hffff8000);
    send_request(OP_DIV, 32'h00050000, 32'h80000000, 32'h0, 32'h0);
    send_request(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
    send_request(OP_DIV, 32'hfffb0000, 32'h00010000, 32'h00030000, 32'hfffd0000);
    send_request(OP_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
    send_request(OP_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
    send_request(OP_NE, 32'h1, 32'h2, 32'h1, 32'h2);
    send_request(OP_NE, 32'h1, 32'h2, 32'h3, 32'h2);
    send_request(OP_LEN, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_request(OP_LEN, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
    send_request(OP_LEN, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff);
    send_request(OP_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    for (int i = 0; i < 6; i++) begin
      send_request(3'(i % 7), ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
    end
    release_bus();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    logic [2:0] op;
    logic [31:0] bx, by;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(49) == 0) ? OP_UNUSED : 3'($urandom_range(6));
      bx = rand_component($urandom_range(9));
      by = rand_component($urandom_range(9));
      if (op inside {OP_EQ, OP_NE} && $urandom_range(1)) begin
        send_request(op, bx, by, bx, $urandom_range(1) ? by : by ^ (32'h1 << $urandom_range(31)));
      end else begin
        send_request(op, rand_component($urandom_range(9)), rand_component($urandom_range(9)),
                     bx, by);
      end
    end
    release_bus();
  endtask

  // receiver held off long enough for the pipeline to fill and push back
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (4 * LATENCY) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 120; i++) begin
        send_request(3'($urandom_range(6)), $urandom, $urandom, $urandom, $urandom);
      end
    join
    release_bus();
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 7, 63);
    test_random(500, 63, 7);
    test_backpressure();
    test_random(550, 0, 0);
    drain();
    if (error_count == 0) begin
      $display("** vector2d_alu_core: PASSED **");
    end else begin
      $display("** vector2d_alu_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/vec2d_pkg.sv
src/vec2d_front.sv
src/vec2d_iter.sv
src/vec2d_back.sv
src/vector2d_alu_core.sv
tb/testbench.sv
